// File: rtl/sveu_pkg.sv
// ----------------------------------------------------------------------------
// sveu_pkg: shared types and constants of the stack machine execute unit
// Field widths, decoded item format, configuration registers and
// register file helpers.
// ----------------------------------------------------------------------------
package sveu_pkg;

  // Sizing
  localparam int NUM_REGS   = 8;
  localparam int MEM_WORDS  = 4096;
  localparam int MEM_AW     = $clog2(MEM_WORDS);
  localparam int DATA_W     = 16;
  localparam int IDX_W      = 3;
  localparam int MODE_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_OUT_W = 12;

  // Decode queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [DATA_W-1:0] MEM_MASK  = DATA_W'(MEM_WORDS - 1);
  localparam logic [DATA_W-1:0] JUMP_BASE = 16'h2fff;

  // Reset values of the configuration registers
  localparam logic [IDX_W-1:0]  PC_INDEX_RST   = 3'd5;
  localparam logic [IDX_W-1:0]  SP_INDEX_RST   = 3'd6;
  localparam logic [IDX_W-1:0]  COND_INDEX_RST = 3'd7;
  localparam logic [DATA_W-1:0] LESS_CODE_RST  = 16'd2;
  localparam logic [DATA_W-1:0] EQUAL_CODE_RST = 16'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_MOV  = 4'd0,
    MODE_ADD  = 4'd1,
    MODE_SUB  = 4'd2,
    MODE_AND  = 4'd3,
    MODE_XOR  = 4'd4,
    MODE_CMP  = 4'd5,
    MODE_JUMP = 4'd6,
    MODE_JME  = 4'd7,
    MODE_PUSH = 4'd8,
    MODE_POP  = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_ALU,
    KIND_CMP,
    KIND_JUMP,
    KIND_JME,
    KIND_PUSH,
    KIND_POP
  } kind_t;

  typedef enum logic [2:0] {
    ALU_MOV,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_XOR
  } alu_fn_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PC_INDEX   = 3'd0,
    CFG_SP_INDEX   = 3'd1,
    CFG_COND_INDEX = 3'd2,
    CFG_LESS_CODE  = 3'd3,
    CFG_EQUAL_CODE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    kind_t               kind;
    alu_fn_t             alu_fn;
    logic [IDX_W-1:0]    reg_index;
    logic [DATA_W-1:0]   operand;
  } dec_t;

  typedef struct packed {
    logic [IDX_W-1:0]    pc_index;
    logic [IDX_W-1:0]    sp_index;
    logic [IDX_W-1:0]    cond_index;
    logic [DATA_W-1:0]   less_code;
    logic [DATA_W-1:0]   equal_code;
  } cfg_t;

  typedef logic [NUM_REGS-1:0][DATA_W-1:0] rf_t;

  // Indexes at or above NUM_REGS read as zero
  function automatic logic [DATA_W-1:0] rf_read(rf_t rf, logic [IDX_W-1:0] idx);
    logic [DATA_W-1:0] v;
    v = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (int'(idx) == i) v = rf[i];
    end
    return v;
  endfunction

  // Writes to indexes at or above NUM_REGS are dropped
  function automatic rf_t rf_write(rf_t rf, logic [IDX_W-1:0] idx,
                                   logic [DATA_W-1:0] v);
    rf_t r;
    r = rf;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (int'(idx) == i) r[i] = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/sveu_ram.sv
// ----------------------------------------------------------------------------
// sveu_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module sveu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sveu_front.sv
// ----------------------------------------------------------------------------
// sveu_front: input decode
// Accepts items and classifies the mode into an operation kind.
// ----------------------------------------------------------------------------
module sveu_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sveu_pkg::MODE_W-1:0]  in_mode,
  input  logic [sveu_pkg::IDX_W-1:0]   in_reg_index,
  input  logic [sveu_pkg::DATA_W-1:0]  in_operand,
  output logic                         q_valid,
  input  logic                         q_ready,
  output sveu_pkg::dec_t               q_data
);

  sveu_pkg::kind_t   kind;
  sveu_pkg::alu_fn_t alu_fn;

  always_comb begin
    kind   = sveu_pkg::KIND_NOP;
    alu_fn = sveu_pkg::ALU_MOV;
    unique case (sveu_pkg::mode_t'(in_mode))
      sveu_pkg::MODE_MOV:  begin kind = sveu_pkg::KIND_ALU; alu_fn = sveu_pkg::ALU_MOV; end
      sveu_pkg::MODE_ADD:  begin kind = sveu_pkg::KIND_ALU; alu_fn = sveu_pkg::ALU_ADD; end
      sveu_pkg::MODE_SUB:  begin kind = sveu_pkg::KIND_ALU; alu_fn = sveu_pkg::ALU_SUB; end
      sveu_pkg::MODE_AND:  begin kind = sveu_pkg::KIND_ALU; alu_fn = sveu_pkg::ALU_AND; end
      sveu_pkg::MODE_XOR:  begin kind = sveu_pkg::KIND_ALU; alu_fn = sveu_pkg::ALU_XOR; end
      sveu_pkg::MODE_CMP:  kind = sveu_pkg::KIND_CMP;
      sveu_pkg::MODE_JUMP: kind = sveu_pkg::KIND_JUMP;
      sveu_pkg::MODE_JME:  kind = sveu_pkg::KIND_JME;
      sveu_pkg::MODE_PUSH: kind = sveu_pkg::KIND_PUSH;
      sveu_pkg::MODE_POP:  kind = sveu_pkg::KIND_POP;
      default:             kind = sveu_pkg::KIND_NOP;  // unused modes
    endcase
  end

  assign q_valid          = in_valid;
  assign in_ready         = q_ready;
  assign q_data.kind      = kind;
  assign q_data.alu_fn    = alu_fn;
  assign q_data.reg_index = in_reg_index;
  assign q_data.operand   = in_operand;

endmodule

// File: rtl/sveu_queue.sv
// ----------------------------------------------------------------------------
// sveu_queue: decoded item queue
// Small FIFO between decode and execute; ready depends on fill only.
// ----------------------------------------------------------------------------
module sveu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  sveu_pkg::dec_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sveu_pkg::dec_t pop_data
);

  sveu_pkg::dec_t                entries_r [sveu_pkg::Q_DEPTH];
  logic [sveu_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sveu_pkg::Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sveu_pkg::Q_CW-1:0]     count_r, count_nxt;
  logic                          push, pop;

  assign push_ready = (count_r != sveu_pkg::Q_CW'(sveu_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == sveu_pkg::Q_AW'(sveu_pkg::Q_DEPTH - 1)) ? '0
                                                                       : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == sveu_pkg::Q_AW'(sveu_pkg::Q_DEPTH - 1)) ? '0
                                                                       : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: rtl/sveu_back.sv
// ----------------------------------------------------------------------------
// sveu_back: execute stage
// Register file, stack memory and result register. A pop writes its
// target in the next cycle, from the RAM read data, with forwarding.
// ----------------------------------------------------------------------------
module sveu_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  sveu_pkg::dec_t                   q_data,
  input  sveu_pkg::cfg_t                   cfg,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_dest_written,
  output logic [sveu_pkg::IDX_W-1:0]       out_dest_index,
  output logic [sveu_pkg::DATA_W-1:0]      out_dest_value,
  output logic [sveu_pkg::DATA_W-1:0]      out_sp_after,
  output logic                             out_mem_written,
  output logic [sveu_pkg::ADDR_OUT_W-1:0]  out_mem_address,
  output logic [sveu_pkg::DATA_W-1:0]      out_mem_value
);

  localparam int DW = sveu_pkg::DATA_W;

  sveu_pkg::rf_t               rf_r, rf_nxt, rf_cur, rf_exec;
  logic                        pend_r, pend_nxt;
  logic [sveu_pkg::IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic [DW-1:0]               ram_q;
  logic                        fire;

  // Execute results
  logic [DW-1:0]               r_val, sp_cur, cond_cur, alu_res, cmp_code;
  logic [DW-1:0]               jump_tgt, sp_inc, sp_dec;
  logic                        x_dw, x_mw, x_pop, x_pop_dest, mem_we, mem_re;
  logic [sveu_pkg::IDX_W-1:0]  x_di;
  logic [DW-1:0]               x_dv, x_mv, x_maddr, x_sp_after;

  // Result register
  logic                              o_valid_r, o_valid_nxt;
  logic                              o_dw_r, o_mw_r, o_pop_r, o_pop_dest_r;
  logic [sveu_pkg::IDX_W-1:0]        o_di_r;
  logic [DW-1:0]                     o_dv_r, o_sp_r, o_mv_r;
  logic [sveu_pkg::ADDR_OUT_W-1:0]   o_maddr_r;

  assign fire    = q_valid & (~o_valid_r | out_ready);
  assign q_ready = ~o_valid_r | out_ready;

  // Register view including the late pop write of the previous item
  always_comb begin
    rf_cur = rf_r;
    if (pend_r) rf_cur = sveu_pkg::rf_write(rf_r, pend_idx_r, ram_q);
  end

  always_comb begin
    r_val    = sveu_pkg::rf_read(rf_cur, q_data.reg_index);
    sp_cur   = sveu_pkg::rf_read(rf_cur, cfg.sp_index);
    cond_cur = sveu_pkg::rf_read(rf_cur, cfg.cond_index);
    sp_inc   = sp_cur + 16'd1;
    sp_dec   = sp_cur - 16'd1;
    jump_tgt = sveu_pkg::JUMP_BASE + q_data.operand;

    unique case (q_data.alu_fn)
      sveu_pkg::ALU_MOV: alu_res = q_data.operand;
      sveu_pkg::ALU_ADD: alu_res = r_val + q_data.operand;
      sveu_pkg::ALU_SUB: alu_res = r_val - q_data.operand;
      sveu_pkg::ALU_AND: alu_res = r_val & q_data.operand;
      sveu_pkg::ALU_XOR: alu_res = r_val ^ q_data.operand;
      default:           alu_res = '0;
    endcase

    if (r_val < q_data.operand)       cmp_code = cfg.less_code;
    else if (r_val == q_data.operand) cmp_code = cfg.equal_code;
    else                              cmp_code = '0;

    rf_exec    = rf_cur;
    x_dw       = 1'b0;
    x_di       = '0;
    x_dv       = '0;
    x_mw       = 1'b0;
    x_mv       = '0;
    x_maddr    = '0;
    x_pop      = 1'b0;
    x_pop_dest = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;

    unique case (q_data.kind)
      sveu_pkg::KIND_ALU: begin
        rf_exec = sveu_pkg::rf_write(rf_cur, q_data.reg_index, alu_res);
        x_dw = 1'b1; x_di = q_data.reg_index; x_dv = alu_res;
      end
      sveu_pkg::KIND_CMP: begin
        rf_exec = sveu_pkg::rf_write(rf_cur, cfg.cond_index, cmp_code);
        x_dw = 1'b1; x_di = cfg.cond_index; x_dv = cmp_code;
      end
      sveu_pkg::KIND_JUMP: begin
        rf_exec = sveu_pkg::rf_write(rf_cur, cfg.pc_index, jump_tgt);
        x_dw = 1'b1; x_di = cfg.pc_index; x_dv = jump_tgt;
      end
      sveu_pkg::KIND_JME: begin
        if (cond_cur == cfg.equal_code) begin
          rf_exec = sveu_pkg::rf_write(rf_cur, cfg.pc_index, jump_tgt);
          x_dw = 1'b1; x_di = cfg.pc_index; x_dv = jump_tgt;
        end
      end
      sveu_pkg::KIND_PUSH: begin
        x_maddr = sp_cur & sveu_pkg::MEM_MASK;
        x_mw    = 1'b1;
        x_mv    = q_data.operand;
        mem_we  = 1'b1;
        rf_exec = sveu_pkg::rf_write(rf_cur, cfg.sp_index, sp_inc);
      end
      sveu_pkg::KIND_POP: begin
        // target write follows from RAM data; into sp the decrement wins
        x_maddr    = sp_dec & sveu_pkg::MEM_MASK;
        x_pop      = 1'b1;
        x_pop_dest = (q_data.reg_index != cfg.sp_index);
        x_dw       = x_pop_dest;
        x_di       = x_pop_dest ? q_data.reg_index : '0;
        mem_re     = 1'b1;
        rf_exec    = sveu_pkg::rf_write(rf_cur, cfg.sp_index, sp_dec);
      end
      default: ;
    endcase

    x_sp_after = sveu_pkg::rf_read(rf_exec, cfg.sp_index);
  end

  always_comb begin
    rf_nxt       = fire ? rf_exec : rf_cur;
    pend_nxt     = fire & x_pop_dest;
    pend_idx_nxt = q_data.reg_index;
    if (fire)           o_valid_nxt = 1'b1;
    else if (out_ready) o_valid_nxt = 1'b0;
    else                o_valid_nxt = o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r      <= '0;
      pend_r    <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      rf_r      <= rf_nxt;
      pend_r    <= pend_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    if (fire) begin
      o_dw_r       <= x_dw;
      o_di_r       <= x_di;
      o_dv_r       <= x_dv;
      o_sp_r       <= x_sp_after;
      o_mw_r       <= x_mw;
      o_maddr_r    <= x_maddr[sveu_pkg::ADDR_OUT_W-1:0];
      o_mv_r       <= x_mv;
      o_pop_r      <= x_pop;
      o_pop_dest_r <= x_pop_dest;
    end
  end

  sveu_ram #(
    .WIDTH (DW),
    .DEPTH (sveu_pkg::MEM_WORDS)
  ) u_stack (
    .clk   (clk),
    .we    (fire & mem_we),
    .waddr (x_maddr[sveu_pkg::MEM_AW-1:0]),
    .wdata (q_data.operand),
    .re    (fire & mem_re),
    .raddr (x_maddr[sveu_pkg::MEM_AW-1:0]),
    .rdata (ram_q)
  );

  // RAM read data holds while the result waits: reads only issue on fire
  assign out_valid        = o_valid_r;
  assign out_dest_written = o_dw_r;
  assign out_dest_index   = o_di_r;
  assign out_dest_value   = o_pop_dest_r ? ram_q : o_dv_r;
  assign out_sp_after     = o_sp_r;
  assign out_mem_written  = o_mw_r;
  assign out_mem_address  = o_maddr_r;
  assign out_mem_value    = o_pop_r ? ram_q : o_mv_r;

endmodule

// File: rtl/stack_vm_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_vm_execute_unit: execute stage of a small 16-bit stack machine
// Register file, stack memory, decode front end and execute back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one instruction item per accept,
//   carrying mode, target register index and a 16-bit operand.
//   Output channel (out_valid/out_ready): exactly one result item per
//   instruction, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes the
//   role indexes and condition codes; always ready. The user must write it
//   only when idle; the block does not enforce this.
//   Path: each item goes through the decode queue, then the result register.
//   Throughput: one item per cycle sustained while out_ready stays high. The
//   execute stage keeps the register file in flops and does one instruction
//   per cycle when not stalled; a pop's target register is filled from the
//   stack RAM in the cycle after the pop and forwarded to the next item.
//   Stalls: a held result stops the execute stage; the 2-entry decode queue
//   then fills and drops in_ready.
//   Reset: register file cleared, config back to defaults, queue and result
//   register emptied. The stack RAM is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module stack_vm_execute_unit (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sveu_pkg::MODE_W-1:0]        in_mode,
  input  logic [sveu_pkg::IDX_W-1:0]         in_reg_index,
  input  logic [sveu_pkg::DATA_W-1:0]        in_operand,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_dest_written,
  output logic [sveu_pkg::IDX_W-1:0]         out_dest_index,
  output logic [sveu_pkg::DATA_W-1:0]        out_dest_value,
  output logic [sveu_pkg::DATA_W-1:0]        out_sp_after,
  output logic                               out_mem_written,
  output logic [sveu_pkg::ADDR_OUT_W-1:0]    out_mem_address,
  output logic [sveu_pkg::DATA_W-1:0]        out_mem_value,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sveu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sveu_pkg::DATA_W-1:0]        cfg_data
);

  sveu_pkg::cfg_t  cfg_r, cfg_nxt;
  sveu_pkg::dec_t  fq_data, qb_data;
  logic            fq_valid, fq_ready;
  logic            qb_valid, qb_ready;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes past the list are ignored.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (sveu_pkg::cfg_reg_t'(cfg_index))
        sveu_pkg::CFG_PC_INDEX:   cfg_nxt.pc_index   = cfg_data[sveu_pkg::IDX_W-1:0];
        sveu_pkg::CFG_SP_INDEX:   cfg_nxt.sp_index   = cfg_data[sveu_pkg::IDX_W-1:0];
        sveu_pkg::CFG_COND_INDEX: cfg_nxt.cond_index = cfg_data[sveu_pkg::IDX_W-1:0];
        sveu_pkg::CFG_LESS_CODE:  cfg_nxt.less_code  = cfg_data;
        sveu_pkg::CFG_EQUAL_CODE: cfg_nxt.equal_code = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pc_index   <= sveu_pkg::PC_INDEX_RST;
      cfg_r.sp_index   <= sveu_pkg::SP_INDEX_RST;
      cfg_r.cond_index <= sveu_pkg::COND_INDEX_RST;
      cfg_r.less_code  <= sveu_pkg::LESS_CODE_RST;
      cfg_r.equal_code <= sveu_pkg::EQUAL_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Front: decode into operation kinds
  // --------------------------------------------------------------------------
  sveu_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_reg_index (in_reg_index),
    .in_operand   (in_operand),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_data       (fq_data)
  );

  // Queue decouples decode from execute stalls
  sveu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // --------------------------------------------------------------------------
  // Back: register file, stack RAM, result register
  // --------------------------------------------------------------------------
  sveu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (qb_valid),
    .q_ready          (qb_ready),
    .q_data           (qb_data),
    .cfg              (cfg_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dest_written (out_dest_written),
    .out_dest_index   (out_dest_index),
    .out_dest_value   (out_dest_value),
    .out_sp_after     (out_sp_after),
    .out_mem_written  (out_mem_written),
    .out_mem_address  (out_mem_address),
    .out_mem_value    (out_mem_value)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // push stores at the stack pointer it then increments
  logic [sveu_pkg::DATA_W-1:0] push_addr_chk;
  logic                        sp_in_range;
  assign push_addr_chk = (out_sp_after - 16'd1) & sveu_pkg::MEM_MASK;
  assign sp_in_range   = (int'(cfg_r.sp_index) < sveu_pkg::NUM_REGS);

  a_push_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_written && sp_in_range |->
      out_mem_address == push_addr_chk[sveu_pkg::ADDR_OUT_W-1:0])
    else $error("push address does not match stack pointer");

  a_push_no_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_written |-> !out_dest_written)
    else $error("push reported a register write");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
